[rtl/xsm_pkg.sv]
package xsm_pkg;

   localparam int unsigned LimbW    = 32;
   localparam int unsigned NumLimbs = 8;
   localparam int unsigned FeW      = 256;
   localparam int unsigned AccW     = 292;
   localparam int unsigned CellXW   = 38;
   localparam int unsigned CellYW   = 40;
   localparam int unsigned CellCW   = 34;
   localparam int unsigned CellTW   = 66;
   localparam int unsigned HiW      = AccW - FeW;

   localparam logic [7:0] LadderTop = 8'd254;
   localparam logic [7:0] InvTop    = 8'd253;
   localparam logic [7:0] InvSkipA  = 8'd2;
   localparam logic [7:0] InvSkipB  = 8'd4;
   localparam logic [16:0] A24      = 17'd121666;
   localparam logic [5:0] Fold38    = 6'd38;
   localparam logic [4:0] Fold19    = 5'd19;
   localparam logic [257:0] P4      = (258'd1 << 257) - 258'd76;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_SETK, OP_SETU, OP_CAN1, OP_CAN2
   } op_type;

   typedef enum logic [3:0] {
      R_X1, R_X2, R_Z2, R_X3, R_Z3, R_A, R_B, R_AA, R_BB, R_E, R_DA, R_CB,
      R_K24, R_ACC, R_ZERO
   } reg_type;

   typedef struct packed {
      op_type      op;
      reg_type     dst;
      reg_type     sa;
      reg_type     sb;
      logic [16:0] k;
   } instr_type;

   localparam logic [4:0] PC_INIT_END = 5'd6;
   localparam logic [4:0] PC_STEP     = 5'd7;
   localparam logic [4:0] PC_STEP_END = 5'd24;
   localparam logic [4:0] PC_INV      = 5'd25;
   localparam logic [4:0] PC_SQR      = 5'd26;
   localparam logic [4:0] PC_MULZ     = 5'd27;
   localparam logic [4:0] PC_FIN      = 5'd28;
   localparam logic [4:0] PC_CAN2     = 5'd30;

   function automatic instr_type mk(input op_type op, input reg_type d, input reg_type a,
                                    input reg_type b, input logic [16:0] k);
      instr_type r;
      r.op  = op;
      r.dst = d;
      r.sa  = a;
      r.sb  = b;
      r.k   = k;
      return r;
   endfunction

   function automatic instr_type prog(input logic [4:0] pc);
      instr_type r;
      case (pc)
         5'd0:    r = mk(OP_SETU, R_X1,   R_X1,  R_X1,  17'd0);
         5'd1:    r = mk(OP_SETU, R_X3,   R_X1,  R_X1,  17'd0);
         5'd2:    r = mk(OP_SETK, R_X2,   R_X1,  R_X1,  17'd1);
         5'd3:    r = mk(OP_SETK, R_Z2,   R_X1,  R_X1,  17'd0);
         5'd4:    r = mk(OP_SETK, R_Z3,   R_X1,  R_X1,  17'd1);
         5'd5:    r = mk(OP_SETK, R_K24,  R_X1,  R_X1,  A24);
         5'd6:    r = mk(OP_SETK, R_ZERO, R_X1,  R_X1,  17'd0);
         5'd7:    r = mk(OP_ADD,  R_A,    R_X2,  R_Z2,  17'd0);
         5'd8:    r = mk(OP_SUB,  R_B,    R_X2,  R_Z2,  17'd0);
         5'd9:    r = mk(OP_MUL,  R_AA,   R_A,   R_A,   17'd0);
         5'd10:   r = mk(OP_MUL,  R_BB,   R_B,   R_B,   17'd0);
         5'd11:   r = mk(OP_MUL,  R_X2,   R_AA,  R_BB,  17'd0);
         5'd12:   r = mk(OP_SUB,  R_E,    R_AA,  R_BB,  17'd0);
         5'd13:   r = mk(OP_SUB,  R_DA,   R_X3,  R_Z3,  17'd0);
         5'd14:   r = mk(OP_MUL,  R_DA,   R_DA,  R_A,   17'd0);
         5'd15:   r = mk(OP_ADD,  R_CB,   R_X3,  R_Z3,  17'd0);
         5'd16:   r = mk(OP_MUL,  R_CB,   R_CB,  R_B,   17'd0);
         5'd17:   r = mk(OP_ADD,  R_X3,   R_DA,  R_CB,  17'd0);
         5'd18:   r = mk(OP_MUL,  R_X3,   R_X3,  R_X3,  17'd0);
         5'd19:   r = mk(OP_SUB,  R_Z3,   R_DA,  R_CB,  17'd0);
         5'd20:   r = mk(OP_MUL,  R_Z3,   R_Z3,  R_Z3,  17'd0);
         5'd21:   r = mk(OP_MUL,  R_Z3,   R_Z3,  R_X1,  17'd0);
         5'd22:   r = mk(OP_MUL,  R_Z2,   R_E,   R_K24, 17'd0);
         5'd23:   r = mk(OP_ADD,  R_Z2,   R_Z2,  R_BB,  17'd0);
         5'd24:   r = mk(OP_MUL,  R_Z2,   R_Z2,  R_E,   17'd0);
         5'd25:   r = mk(OP_ADD,  R_ACC,  R_Z2,  R_ZERO, 17'd0);
         5'd26:   r = mk(OP_MUL,  R_ACC,  R_ACC, R_ACC, 17'd0);
         5'd27:   r = mk(OP_MUL,  R_ACC,  R_ACC, R_Z2,  17'd0);
         5'd28:   r = mk(OP_MUL,  R_A,    R_X2,  R_ACC, 17'd0);
         5'd29:   r = mk(OP_CAN1, R_A,    R_A,   R_A,   17'd0);
         default: r = mk(OP_CAN2, R_A,    R_A,   R_A,   17'd0);
      endcase
      return r;
   endfunction

   // logical to physical register, follows the ladder swap
   function automatic reg_type remap(input reg_type r, input logic sw);
      reg_type o;
      o = r;
      if (sw) begin
         unique case (r)
            R_X2:    o = R_X3;
            R_X3:    o = R_X2;
            R_Z2:    o = R_Z3;
            R_Z3:    o = R_Z2;
            default: o = r;
         endcase
      end
      return o;
   endfunction

endpackage

[rtl/xsm_mul_cell.sv]
module xsm_mul_cell (
   input  logic                          clock,
   input  logic                          clear,
   input  logic                          enable,
   input  logic [xsm_pkg::LimbW-1:0]     a_limb,
   input  logic [xsm_pkg::LimbW-1:0]     b_limb,
   input  logic [xsm_pkg::CellXW-1:0]    x_in,
   input  logic [xsm_pkg::CellYW-1:0]    y_in,
   output logic [xsm_pkg::LimbW-1:0]     lo_out,
   output logic [xsm_pkg::CellCW-1:0]    carry_out
);
   import xsm_pkg::*;

   logic [LimbW-1:0]   lo_ff, lo_in;
   logic [CellCW-1:0]  carry_ff, carry_in;
   logic [2*LimbW-1:0] prod;
   logic [CellTW-1:0]  t;

   always_comb begin
      prod     = a_limb * b_limb;
      t        = CellTW'(prod) + CellTW'(x_in) + CellTW'(y_in);
      lo_in    = t[LimbW-1:0];
      carry_in = t[LimbW+CellCW-1:LimbW];
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         lo_ff    <= '0;
         carry_ff <= '0;
      end else if (enable) begin
         lo_ff    <= lo_in;
         carry_ff <= carry_in;
      end
   end

   assign lo_out    = lo_ff;
   assign carry_out = carry_ff;

endmodule

[rtl/x25519_scalar_multiply.sv]
// X25519 scalar multiplier over GF(2^255-19). Load the scalar and the peer u-coordinate as
// four little-endian 64-bit words (tuser carries word_index and use_base_point); the item
// with word_index 3 starts the computation, with use_base_point selecting u = 9. The scalar
// is clamped and bit 255 of u is ignored. Four result words follow, tlast on the fourth.
// A key exchange runs 255 ladder steps of 10 multiplies and 8 adds, then 506 multiplies
// for the inversion. Every field multiply runs through the row of eight 32x32 multiplier
// cells (one operand limb per cycle, then carry resolve and reduction). Input is not
// taken while a computation runs.
module x25519_scalar_multiply (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // scalar_word, point_word
   input  logic [2:0]   req_tuser,  // word_index, use_base_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // result_word
   output logic [1:0]   rsp_tuser,  // result_index
   output logic         rsp_tlast
);
   import xsm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_READ  = 8'b00000010,
      ST_EXEC  = 8'b00000100,
      ST_MUL   = 8'b00001000,
      ST_SUM   = 8'b00010000,
      ST_FOLD  = 8'b00100000,
      ST_WRITE = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  pc_ff, pc_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  inv_ff, inv_in;
   logic        remap_ff, remap_in;
   logic        swap_ff, swap_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  fold_ff, fold_in;
   logic [1:0]  idx_ff, idx_in;
   logic        base_ff;
   logic [63:0] scalar_ff [4];
   logic [63:0] upoint_ff [4];
   logic [FeW-1:0]  rd_a_ff, rd_b_ff;
   logic [AccW-1:0] w_ff, w_in;
   logic [FeW-1:0]  regs_mem [15];

   instr_type       instr;
   logic [FeW-1:0]  kval, uval, can_y;
   logic [7:0]      npos;
   logic            in_fire, out_fire;
   logic [AccW-1:0] fold_v, sum_v, cl_v, ch_v, lo_v;
   logic [HiW-1:0]  hi;

   logic [LimbW-1:0]  lo_w [NumLimbs];
   logic [CellCW-1:0] c_w  [NumLimbs];
   logic [CellXW-1:0] x_w  [NumLimbs];
   logic [CellYW-1:0] y_w  [NumLimbs];

   assign instr    = prog(pc_ff);
   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign kval = {2'b01, scalar_ff[3][61:0], scalar_ff[2], scalar_ff[1],
                  scalar_ff[0][63:3], 3'b000};
   assign uval = base_ff ? FeW'(9)
                         : {1'b0, upoint_ff[3][62:0], upoint_ff[2], upoint_ff[1], upoint_ff[0]};

   // row of multiplier cells, partial sums shift one limb up per cycle in ST_MUL
   always_comb begin
      for (int i = 0; i < NumLimbs; i++) begin
         if (i == 0) begin
            x_w[i] = CellXW'(lo_w[NumLimbs-1]) * CellXW'(Fold38);
            y_w[i] = CellYW'(c_w[NumLimbs-2]) * CellYW'(Fold38);
         end else if (i == 1) begin
            x_w[i] = CellXW'(lo_w[0]);
            y_w[i] = CellYW'(c_w[NumLimbs-1]) * CellYW'(Fold38);
         end else begin
            x_w[i] = CellXW'(lo_w[i-1]);
            y_w[i] = CellYW'(c_w[i-2]);
         end
      end
   end

   for (genvar g = 0; g < NumLimbs; g++) begin : g_cell
      xsm_mul_cell u_cell (
         .clock     (clock),
         .clear     (state_ff == ST_EXEC),
         .enable    (state_ff == ST_MUL),
         .a_limb    (rd_a_ff[g*LimbW +: LimbW]),
         .b_limb    (rd_b_ff[{cnt_ff, 5'b00000} +: LimbW]),
         .x_in      (x_w[g]),
         .y_in      (y_w[g]),
         .lo_out    (lo_w[g]),
         .carry_out (c_w[g])
      );
   end

   always_comb begin
      lo_v = '0;
      cl_v = '0;
      ch_v = '0;
      for (int i = 0; i < NumLimbs; i++) begin
         lo_v[LimbW*i +: LimbW] = lo_w[i];
      end
      for (int i = 0; i < NumLimbs - 1; i++) begin
         cl_v[LimbW*(i+1) +: LimbW] = c_w[i][LimbW-1:0];
         ch_v[LimbW*(i+2) +: 2]     = c_w[i][CellCW-1:LimbW];
      end
      cl_v[FeW +: CellCW] = c_w[NumLimbs-1];
      sum_v  = lo_v + cl_v + ch_v;
      hi     = w_ff[AccW-1:FeW];
      fold_v = AccW'(w_ff[FeW-1:0]) + (AccW'(hi) << 5) + (AccW'(hi) << 2) + (AccW'(hi) << 1);
      can_y  = rd_a_ff + FeW'(Fold19);
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      pos_in   = pos_ff;
      inv_in   = inv_ff;
      remap_in = remap_ff;
      swap_in  = swap_ff;
      cnt_in   = cnt_ff;
      fold_in  = fold_ff;
      idx_in   = idx_ff;
      w_in     = w_ff;
      npos     = pos_ff - 8'd1;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_fire && req_tuser[1:0] == 2'd3) begin
               pc_in    = '0;
               remap_in = 1'b0;
               swap_in  = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_WRITE;
            case (instr.op)
               OP_ADD: begin
                  w_in     = AccW'(rd_a_ff) + AccW'(rd_b_ff);
                  fold_in  = 2'd2;
                  state_in = ST_FOLD;
               end
               OP_SUB: begin
                  w_in     = AccW'(rd_a_ff) + AccW'(P4) - AccW'(rd_b_ff);
                  fold_in  = 2'd2;
                  state_in = ST_FOLD;
               end
               OP_MUL: begin
                  cnt_in   = 3'd7;
                  state_in = ST_MUL;
               end
               OP_SETK: w_in = AccW'(instr.k);
               OP_SETU: w_in = AccW'(uval);
               OP_CAN1: w_in = AccW'(rd_a_ff[FeW-2:0])
                               + (rd_a_ff[FeW-1] ? AccW'(Fold19) : AccW'(0));
               OP_CAN2: w_in = can_y[FeW-1] ? AccW'(can_y[FeW-2:0]) : AccW'(rd_a_ff);
               default: w_in = w_ff;
            endcase
         end
         ST_MUL: begin
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) state_in = ST_SUM;
         end
         ST_SUM: begin
            w_in     = sum_v;
            fold_in  = 2'd2;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            w_in    = fold_v;
            fold_in = fold_ff - 2'd1;
            if (fold_ff == 2'd0) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_READ;
            pc_in    = pc_ff + 5'd1;
            case (pc_ff)
               PC_INIT_END: begin
                  pos_in   = LadderTop;
                  remap_in = remap_ff ^ swap_ff ^ kval[LadderTop];
                  swap_in  = kval[LadderTop];
               end
               PC_STEP_END: begin
                  if (pos_ff == 8'd0) begin
                     remap_in = remap_ff ^ swap_ff;
                     pc_in    = PC_INV;
                  end else begin
                     pos_in   = npos;
                     remap_in = remap_ff ^ swap_ff ^ kval[npos];
                     swap_in  = kval[npos];
                     pc_in    = PC_STEP;
                  end
               end
               PC_INV: inv_in = InvTop;
               PC_SQR: begin
                  if (inv_ff == InvSkipA || inv_ff == InvSkipB) begin
                     inv_in = inv_ff - 8'd1;
                     pc_in  = PC_SQR;
                  end
               end
               PC_MULZ: begin
                  if (inv_ff == 8'd0) begin
                     pc_in = PC_FIN;
                  end else begin
                     inv_in = inv_ff - 8'd1;
                     pc_in  = PC_SQR;
                  end
               end
               PC_CAN2: begin
                  idx_in   = 2'd0;
                  state_in = ST_OUT;
               end
               default: ;
            endcase
         end
         ST_OUT: begin
            if (out_fire) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         pos_ff   <= '0;
         inv_ff   <= '0;
         remap_ff <= 1'b0;
         swap_ff  <= 1'b0;
         cnt_ff   <= '0;
         fold_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         pos_ff   <= pos_in;
         inv_ff   <= inv_in;
         remap_ff <= remap_in;
         swap_ff  <= swap_in;
         cnt_ff   <= cnt_in;
         fold_ff  <= fold_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      if (in_fire) begin
         scalar_ff[req_tuser[1:0]] <= req_tdata[63:0];
         upoint_ff[req_tuser[1:0]] <= req_tdata[127:64];
         if (req_tuser[1:0] == 2'd3) base_ff <= req_tuser[2];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_a_ff <= regs_mem[remap(instr.sa, remap_ff)];
         rd_b_ff <= regs_mem[remap(instr.sb, remap_ff)];
      end
      if (state_ff == ST_WRITE) regs_mem[remap(instr.dst, remap_ff)] <= w_ff[FeW-1:0];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = w_ff[{idx_ff, 6'b000000} +: 64];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 2'd3);

endmodule

[tb/x25519_scalar_multiply_test.sv]
module x25519_scalar_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] START_WORD = 2'd3;
   localparam logic [255:0] FIELD_P = (256'd1 << 255) - 256'd19;
   localparam int unsigned IDLE_LIMIT = 400000;
   localparam int unsigned RANDOM_ITEMS = 124;

   typedef struct {
      logic [1:0]   idx;
      logic [63:0]  scalar;
      logic [63:0]  point;
      logic         base;
      logic         known;
      logic [255:0] known_u;
   } load_row_type;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } out_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // scalar_word, point_word
   logic [2:0]   req_tuser = '0;   // word_index, use_base_point
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;        // result_word
   logic [1:0]   rsp_tuser;        // result_index
   logic         rsp_tlast;

   logic [63:0]  scalar_words [4];
   logic [63:0]  point_words [4];
   out_word_type pending_words [$];
   load_row_type directed_rows [$];
   int unsigned  mismatches = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  burst_left = 4;
   int unsigned  cycle_count = 0;

   x25519_scalar_multiply dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [255:0] f_mul(input logic [255:0] a, input logic [255:0] b);
      logic [511:0] t;
      t = {256'd0, a} * {256'd0, b};
      t = t % {256'd0, FIELD_P};
      return t[255:0];
   endfunction

   function automatic logic [255:0] f_add(input logic [255:0] a, input logic [255:0] b);
      logic [256:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= {1'b0, FIELD_P}) t = t - {1'b0, FIELD_P};
      return t[255:0];
   endfunction

   function automatic logic [255:0] f_sub(input logic [255:0] a, input logic [255:0] b);
      logic [256:0] t;
      t = {1'b0, a} + {1'b0, FIELD_P} - {1'b0, b};
      if (t >= {1'b0, FIELD_P}) t = t - {1'b0, FIELD_P};
      return t[255:0];
   endfunction

   function automatic logic [255:0] shared_u(input logic base);
      logic [255:0] k, x1, x2, z2, x3, z3, a, b, aa, bb, e, da, cb, tmp, inv, ex;
      logic swap, bit_k;
      k = {scalar_words[3], scalar_words[2], scalar_words[1], scalar_words[0]};
      k[2:0] = 3'b000;
      k[255] = 1'b0;
      k[254] = 1'b1;
      if (base) x1 = 256'd9;
      else begin
         x1 = {point_words[3], point_words[2], point_words[1], point_words[0]};
         x1[255] = 1'b0;
         if (x1 >= FIELD_P) x1 = x1 - FIELD_P;
      end
      x2 = 256'd1; z2 = 256'd0; x3 = x1; z3 = 256'd1; swap = 1'b0;
      for (int pos = 254; pos >= 0; pos--) begin
         bit_k = k[pos];
         if (swap ^ bit_k) begin
            tmp = x2; x2 = x3; x3 = tmp;
            tmp = z2; z2 = z3; z3 = tmp;
         end
         swap = bit_k;
         a  = f_add(x2, z2);
         b  = f_sub(x2, z2);
         aa = f_mul(a, a);
         bb = f_mul(b, b);
         x2 = f_mul(aa, bb);
         e  = f_sub(aa, bb);
         da = f_mul(f_sub(x3, z3), a);
         cb = f_mul(f_add(x3, z3), b);
         x3 = f_mul(f_add(da, cb), f_add(da, cb));
         z3 = f_mul(f_mul(f_sub(da, cb), f_sub(da, cb)), x1);
         z2 = f_mul(f_add(f_mul(e, 256'd121666), bb), e);
      end
      if (swap) begin
         x2 = x3;
         z2 = z3;
      end
      ex = FIELD_P - 256'd2;
      inv = 256'd1;
      for (int i = 254; i >= 0; i--) begin
         inv = f_mul(inv, inv);
         if (ex[i]) inv = f_mul(inv, z2);
      end
      return f_mul(x2, inv);
   endfunction

   task automatic expect_words(input logic [255:0] u);
      out_word_type w;
      for (int i = 0; i < 4; i++) begin
         w.word  = u[64*i +: 64];
         w.index = i[1:0];
         w.last  = (i == 3);
         pending_words.push_back(w);
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // drives one item, holds it until taken, then runs the predictor on the start word
   task automatic load_word(input load_row_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {r.point, r.scalar};
      req_tuser  <= {r.base, r.idx};
      do @(posedge clock); while (!req_tready);
      scalar_words[r.idx] = r.scalar;
      point_words[r.idx]  = r.point;
      if (r.idx == START_WORD) expect_words(r.known ? r.known_u : shared_u(r.base));
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return 64'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic load_row_type row(input logic [1:0] idx, input logic [63:0] s,
                                        input logic [63:0] p, input logic base);
      load_row_type r;
      r.idx = idx; r.scalar = s; r.point = p; r.base = base;
      r.known = 1'b0; r.known_u = '0;
      return r;
   endfunction

   // receiver: rotates between always ready, a periodic stall pattern and random stalls
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case ((cycle_count / 700) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= (cycle_count % 5) != 2;
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            report("unexpected item", rsp_tdata, '0);
         end else begin
            out_word_type w;
            w = pending_words.pop_front();
            if (rsp_tdata !== w.word) report("result_word", rsp_tdata, w.word);
            if (rsp_tuser !== w.index) report("result_index", 64'(rsp_tuser), 64'(w.index));
            if (rsp_tlast !== w.last) report("last", 64'(rsp_tlast), 64'(w.last));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned sent;
      logic [1:0] order [3];
      int unsigned j;
      logic [1:0] t;

      // all ones scalar and non-canonical u (2^255-1 after masking)
      for (int i = 0; i < 4; i++) directed_rows.push_back(row(i[1:0], '1, '1, 1'b0));
      // base mode, zero scalar, point ignored
      for (int i = 0; i < 4; i++) directed_rows.push_back(row(i[1:0], '0, '1, 1'b1));
      // u = 0 gives a zero denominator
      for (int i = 0; i < 4; i++) directed_rows.push_back(row(i[1:0], {$urandom, $urandom},
                                                               '0, 1'b0));
      directed_rows[$].known = 1'b1;
      // u = p, same as zero
      directed_rows.push_back(row(2'd0, '1, 64'hffff_ffff_ffff_ffed, 1'b0));
      directed_rows.push_back(row(2'd1, '1, '1, 1'b0));
      directed_rows.push_back(row(2'd2, '1, '1, 1'b0));
      directed_rows.push_back(row(START_WORD, '1, 64'h7fff_ffff_ffff_ffff, 1'b0));
      directed_rows[$].known = 1'b1;
      // u = p + 1 and bit 255 set
      directed_rows.push_back(row(2'd0, 64'h5, 64'hffff_ffff_ffff_ffee, 1'b0));
      directed_rows.push_back(row(START_WORD, 64'h8000_0000_0000_0000, '1, 1'b0));
      // restart with only the last word new, base mode
      directed_rows.push_back(row(START_WORD, 64'h1234_5678_9abc_def0, '0, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) load_word(directed_rows[i]);

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            // full load in shuffled order, then the start word
            order = '{2'd0, 2'd1, 2'd2};
            for (int i = 2; i > 0; i--) begin
               j = $urandom_range(0, i);
               t = order[i]; order[i] = order[j]; order[j] = t;
            end
            for (int i = 0; i < 3; i++) begin
               load_word(row(order[i], pick_word(), pick_word(), 1'($urandom)));
               sent++;
            end
            load_word(row(START_WORD, pick_word(), pick_word(), 1'($urandom)));
            sent++;
         end else begin
            // partial reload, possibly starting from old words
            load_word(row(2'($urandom), pick_word(), pick_word(), 1'($urandom)));
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
